// File: sv/avcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcc_pkg
// phase, tag and status codes shared by the decoder configuration record parser
// ----------------------------------------------------------------------------
package avcc_pkg;

    localparam int PHASE_W = 4;

    // parse phase codes
    localparam logic [PHASE_W-1:0] PH_VERSION    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_PROFILE    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_COMPAT     = 4'd2;
    localparam logic [PHASE_W-1:0] PH_LEVEL      = 4'd3;
    localparam logic [PHASE_W-1:0] PH_LENSIZE    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_SPS_COUNT  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_SPS_LEN_HI = 4'd6;
    localparam logic [PHASE_W-1:0] PH_SPS_LEN_LO = 4'd7;
    localparam logic [PHASE_W-1:0] PH_SPS_DATA   = 4'd8;
    localparam logic [PHASE_W-1:0] PH_PPS_COUNT  = 4'd9;
    localparam logic [PHASE_W-1:0] PH_PPS_LEN_HI = 4'd10;
    localparam logic [PHASE_W-1:0] PH_PPS_LEN_LO = 4'd11;
    localparam logic [PHASE_W-1:0] PH_PPS_DATA   = 4'd12;
    localparam logic [PHASE_W-1:0] PH_DONE       = 4'd13;
    localparam logic [PHASE_W-1:0] PH_ERROR      = 4'd14;

    typedef logic [1:0] tag_t;
    localparam tag_t TAG_HEADER  = 2'd0;
    localparam tag_t TAG_SPS     = 2'd1;
    localparam tag_t TAG_PPS     = 2'd2;
    localparam tag_t TAG_IGNORED = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t ST_BUSY  = 2'd0;
    localparam status_t ST_DONE  = 2'd1;
    localparam status_t ST_MANY  = 2'd2;
    localparam status_t ST_TRUNC = 2'd3;

    // widest set count that is still accepted
    localparam logic [7:0] MAX_SET_COUNT = 8'd1;

endpackage

// File: sv/avcc_config_record_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcc_config_record_parser
// byte-serial parser for an h.264 decoder configuration record
// ----------------------------------------------------------------------------
// usage:
//   input channel carries one record word per beat (in_byte) with
//   end_of_record high on the last word of the record. each accepted word
//   yields exactly one result word on the output channel: the byte passed
//   through, its tag (header/length, sps, pps, ignored), set_last on the
//   final payload byte of each parameter set, the running parse status and
//   the header fields captured so far.
//   the result is registered: it sits in the output register from the
//   edge that takes the word. throughput: one word per cycle while the receiver does not stall; the parse
//   phase and the 16-bit payload down-counter update on that same edge.
//   a new word is taken while the output register is empty or is being
//   drained in the same cycle, so a stalled receiver holds the result and
//   backs up the input channel with no word lost.
//   reset empties the output register and returns the parser to the
//   version byte; the end of each record returns the parser to the version byte after its result.
// ----------------------------------------------------------------------------
module avcc_config_record_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 end_of_record,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output avcc_pkg::tag_t       byte_tag,
    output logic                 set_last,
    output avcc_pkg::status_t    parse_status,
    output logic [7:0]           profile_idc,
    output logic [7:0]           compat_flags,
    output logic [7:0]           level_idc,
    output logic [1:0]           length_size_minus_one,
    output logic [15:0]          sps_length,
    output logic [15:0]          pps_length
);
    import avcc_pkg::*;

    // parse state
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [15:0]        count_reg, count_next;
    logic [15:0]        sps_len_reg, sps_len_next;
    logic [15:0]        pps_len_reg, pps_len_next;
    logic [7:0]         profile_reg, profile_next;
    logic [7:0]         compat_reg, compat_next;
    logic [7:0]         level_reg, level_next;
    logic [1:0]         lsize_reg, lsize_next;
    status_t            status_reg, status_next;

    // result register
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    tag_t               tag_reg, tag_next;
    logic               last_reg, last_next;
    status_t            ostat_reg;
    logic [7:0]         oprof_reg, ocompat_reg, olevel_reg;
    logic [1:0]         olsize_reg;
    logic [15:0]        osps_reg, opps_reg;

    logic               in_acc;
    logic [15:0]        sps_len_full;
    logic [15:0]        pps_len_full;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_acc   = in_valid && in_ready;

    assign sps_len_full = {sps_len_reg[15:8], in_byte};
    assign pps_len_full = {pps_len_reg[15:8], in_byte};

    // one phase step per word
    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        sps_len_next = sps_len_reg;
        pps_len_next = pps_len_reg;
        profile_next = profile_reg;
        compat_next  = compat_reg;
        level_next   = level_reg;
        lsize_next   = lsize_reg;
        status_next  = status_reg;
        tag_next     = TAG_HEADER;
        last_next    = 1'b0;
        case (phase_reg)
            PH_VERSION:    phase_next = PH_PROFILE;
            PH_PROFILE:
            begin
                profile_next = in_byte;
                phase_next   = PH_COMPAT;
            end
            PH_COMPAT:
            begin
                compat_next = in_byte;
                phase_next  = PH_LEVEL;
            end
            PH_LEVEL:
            begin
                level_next = in_byte;
                phase_next = PH_LENSIZE;
            end
            PH_LENSIZE:
            begin
                lsize_next = in_byte[1:0];
                phase_next = PH_SPS_COUNT;
            end
            PH_SPS_COUNT:
            begin
                // sps count sits in the low five bits
                if ({3'b000, in_byte[4:0]} > MAX_SET_COUNT)
                begin
                    status_next = ST_MANY;
                    phase_next  = PH_ERROR;
                end
                else
                begin
                    phase_next = PH_SPS_LEN_HI;
                end
            end
            PH_SPS_LEN_HI:
            begin
                sps_len_next = {in_byte, 8'h00};
                phase_next   = PH_SPS_LEN_LO;
            end
            PH_SPS_LEN_LO:
            begin
                sps_len_next = sps_len_full;
                count_next   = sps_len_full;
                phase_next   = (sps_len_full != 16'd0) ? PH_SPS_DATA : PH_PPS_COUNT;
            end
            PH_SPS_DATA:
            begin
                tag_next = TAG_SPS;
                if (count_reg <= 16'd1)
                begin
                    last_next  = 1'b1;
                    count_next = 16'd0;
                    phase_next = PH_PPS_COUNT;
                end
                else
                begin
                    count_next = count_reg - 16'd1;
                end
            end
            PH_PPS_COUNT:
            begin
                if (in_byte > MAX_SET_COUNT)
                begin
                    status_next = ST_MANY;
                    phase_next  = PH_ERROR;
                end
                else
                begin
                    phase_next = PH_PPS_LEN_HI;
                end
            end
            PH_PPS_LEN_HI:
            begin
                pps_len_next = {in_byte, 8'h00};
                phase_next   = PH_PPS_LEN_LO;
            end
            PH_PPS_LEN_LO:
            begin
                pps_len_next = pps_len_full;
                count_next   = pps_len_full;
                if (pps_len_full != 16'd0)
                begin
                    phase_next = PH_PPS_DATA;
                end
                else
                begin
                    phase_next  = PH_DONE;
                    status_next = ST_DONE;
                end
            end
            PH_PPS_DATA:
            begin
                tag_next = TAG_PPS;
                if (count_reg <= 16'd1)
                begin
                    last_next   = 1'b1;
                    count_next  = 16'd0;
                    phase_next  = PH_DONE;
                    status_next = ST_DONE;
                end
                else
                begin
                    count_next = count_reg - 16'd1;
                end
            end
            default:       tag_next = TAG_IGNORED;
        endcase
        // record ended before it was complete
        if (end_of_record && (status_next == ST_BUSY))
        begin
            status_next = ST_TRUNC;
        end
    end

    // parse state, back to the version byte after the last word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_VERSION;
            count_reg   <= 16'd0;
            sps_len_reg <= 16'd0;
            pps_len_reg <= 16'd0;
            profile_reg <= 8'd0;
            compat_reg  <= 8'd0;
            level_reg   <= 8'd0;
            lsize_reg   <= 2'd0;
            status_reg  <= ST_BUSY;
        end
        else if (in_acc)
        begin
            if (end_of_record)
            begin
                phase_reg   <= PH_VERSION;
                count_reg   <= 16'd0;
                sps_len_reg <= 16'd0;
                pps_len_reg <= 16'd0;
                profile_reg <= 8'd0;
                compat_reg  <= 8'd0;
                level_reg   <= 8'd0;
                lsize_reg   <= 2'd0;
                status_reg  <= ST_BUSY;
            end
            else
            begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                sps_len_reg <= sps_len_next;
                pps_len_reg <= pps_len_next;
                profile_reg <= profile_next;
                compat_reg  <= compat_next;
                level_reg   <= level_next;
                lsize_reg   <= lsize_next;
                status_reg  <= status_next;
            end
        end
    end

    // output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload, shows the fields as they stand after this word
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            out_byte_reg <= in_byte;
            tag_reg      <= tag_next;
            last_reg     <= last_next;
            ostat_reg    <= status_next;
            oprof_reg    <= profile_next;
            ocompat_reg  <= compat_next;
            olevel_reg   <= level_next;
            olsize_reg   <= lsize_next;
            osps_reg     <= sps_len_next;
            opps_reg     <= pps_len_next;
        end
    end

    assign out_valid             = out_valid_reg;
    assign out_byte              = out_byte_reg;
    assign byte_tag              = tag_reg;
    assign set_last              = last_reg;
    assign parse_status          = ostat_reg;
    assign profile_idc           = oprof_reg;
    assign compat_flags          = ocompat_reg;
    assign level_idc             = olevel_reg;
    assign length_size_minus_one = olsize_reg;
    assign sps_length            = osps_reg;
    assign pps_length            = opps_reg;

    // set_last only ever marks a payload byte
    a_last_on_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (tag_reg == TAG_SPS || tag_reg == TAG_PPS))
        else $error("set_last on a non-payload byte");

    // the last pps byte completes the record
    a_pps_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg && tag_reg == TAG_PPS) |-> (ostat_reg == ST_DONE))
        else $error("final pps byte without complete status");

    // error phase is only reached through the set count check
    a_error_status: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERROR) |-> (status_reg == ST_MANY))
        else $error("error phase without too-many-sets status");

    // end of record restarts the parse
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && end_of_record) |=> (phase_reg == PH_VERSION && status_reg == ST_BUSY))
        else $error("parser did not restart after end of record");

endmodule

// File: tb/sv/avcc_config_record_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcc_config_record_parser_tb
// self-checking bench for the decoder configuration record parser
// ----------------------------------------------------------------------------
// a directed table walks header extremes, zero counts and zero lengths, both
// error codes, bytes after completion and after an error, and an early end.
// random records follow: mostly well formed with random content, some cut
// short (some with full 16-bit lengths), some with too many sets, some noise.
// every accepted word runs through a behavioral parser in the bench, and
// every result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module avcc_config_record_parser_tb;
    import avcc_pkg::*;

    localparam int WORD_TARGET   = 1150;  // parsed words (ignored bytes not counted)
    localparam int CALM_TAIL     = 100;   // last words run with no idling
    localparam int MAX_SHOWN     = 10;
    localparam int RECORD_CAP    = 60;    // bound on records with huge lengths
    localparam int SETTLE_CYCLES = 8;

    // one result word as the parser reports it
    typedef struct packed {
        logic [7:0]  data;
        tag_t        tag;
        logic        last;
        status_t     status;
        logic [7:0]  profile;
        logic [7:0]  compat;
        logic [7:0]  level;
        logic [1:0]  len_size;
        logic [15:0] sps_len;
        logic [15:0] pps_len;
    } parse_result_t;

    // one input word; when fixed is set, tag/last/status are typed in
    typedef struct packed {
        logic [7:0] data;
        logic       eor;
        logic       fixed;
        tag_t       tag;
        logic       last;
        status_t    status;
    } record_word_t;

    localparam record_word_t DIRECTED_WORDS [25] = '{
        // complete record with extreme header bytes and one-byte sets
        '{8'h01, 1'b0, 1'b1, TAG_HEADER,  1'b0, ST_BUSY},   // version right after reset
        '{8'hFF, 1'b0, 1'b0, TAG_HEADER,  1'b0, ST_BUSY},   // profile
        '{8'h00, 1'b0, 1'b0, TAG_HEADER,  1'b0, ST_BUSY},   // compatibility
        '{8'hFF, 1'b0, 1'b0, TAG_HEADER,  1'b0, ST_BUSY},   // level
        '{8'hFF, 1'b0, 1'b0, TAG_HEADER,  1'b0, ST_BUSY},   // length size 3
        '{8'hE1, 1'b0, 1'b0, TAG_HEADER,  1'b0, ST_BUSY},   // one sps, reserved bits set
        '{8'h00, 1'b0, 1'b0, TAG_HEADER,  1'b0, ST_BUSY},
        '{8'h01, 1'b0, 1'b0, TAG_HEADER,  1'b0, ST_BUSY},
        '{8'hFF, 1'b0, 1'b1, TAG_SPS,     1'b1, ST_BUSY},   // only sps byte is also last
        '{8'h01, 1'b0, 1'b0, TAG_HEADER,  1'b0, ST_BUSY},   // one pps
        '{8'h00, 1'b0, 1'b0, TAG_HEADER,  1'b0, ST_BUSY},
        '{8'h01, 1'b0, 1'b0, TAG_HEADER,  1'b0, ST_BUSY},
        '{8'h00, 1'b0, 1'b1, TAG_PPS,     1'b1, ST_DONE},   // record complete
        '{8'hAA, 1'b1, 1'b1, TAG_IGNORED, 1'b0, ST_DONE},   // byte after completion
        // zero sps count and zero length, then a pps count above one
        '{8'h00, 1'b0, 1'b1, TAG_HEADER,  1'b0, ST_BUSY},
        '{8'h00, 1'b0, 1'b0, TAG_HEADER,  1'b0, ST_BUSY},
        '{8'h00, 1'b0, 1'b0, TAG_HEADER,  1'b0, ST_BUSY},
        '{8'h00, 1'b0, 1'b0, TAG_HEADER,  1'b0, ST_BUSY},
        '{8'h00, 1'b0, 1'b0, TAG_HEADER,  1'b0, ST_BUSY},
        '{8'h00, 1'b0, 1'b0, TAG_HEADER,  1'b0, ST_BUSY},
        '{8'h00, 1'b0, 1'b0, TAG_HEADER,  1'b0, ST_BUSY},
        '{8'h00, 1'b0, 1'b1, TAG_HEADER,  1'b0, ST_BUSY},   // zero length skips payload
        '{8'hFF, 1'b0, 1'b1, TAG_HEADER,  1'b0, ST_MANY},
        '{8'h55, 1'b1, 1'b1, TAG_IGNORED, 1'b0, ST_MANY},   // after the error
        // record that ends on its first byte
        '{8'h80, 1'b1, 1'b1, TAG_HEADER,  1'b0, ST_TRUNC}
    };

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic [7:0]           in_byte       = '0;
    logic                 end_of_record = 1'b0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic [7:0]           out_byte;
    tag_t                 byte_tag;
    logic                 set_last;
    status_t              parse_status;
    logic [7:0]           profile_idc;
    logic [7:0]           compat_flags;
    logic [7:0]           level_idc;
    logic [1:0]           length_size_minus_one;
    logic [15:0]          sps_length;
    logic [15:0]          pps_length;

    // bench copy of the parser state
    logic [PHASE_W-1:0]   cur_phase;
    logic [15:0]          bytes_left;
    logic [15:0]          got_sps_len;
    logic [15:0]          got_pps_len;
    logic [7:0]           got_profile;
    logic [7:0]           got_compat;
    logic [7:0]           got_level;
    logic [1:0]           got_len_size;
    status_t              got_status;

    parse_result_t        pending_results [$];
    logic [7:0]           record_q [$];
    int                   mismatches   = 0;
    int                   parsed_words = 0;
    bit                   idling_on    = 1'b1;
    int                   stall_left   = 0;

    avcc_config_record_parser dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_ready              (in_ready),
        .in_byte               (in_byte),
        .end_of_record         (end_of_record),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .out_byte              (out_byte),
        .byte_tag              (byte_tag),
        .set_last              (set_last),
        .parse_status          (parse_status),
        .profile_idc           (profile_idc),
        .compat_flags          (compat_flags),
        .level_idc             (level_idc),
        .length_size_minus_one (length_size_minus_one),
        .sps_length            (sps_length),
        .pps_length            (pps_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void clear_parser();
        cur_phase    = PH_VERSION;
        bytes_left   = '0;
        got_sps_len  = '0;
        got_pps_len  = '0;
        got_profile  = '0;
        got_compat   = '0;
        got_level    = '0;
        got_len_size = '0;
        got_status   = ST_BUSY;
    endfunction

    // advance the bench parser by one byte and return the word it reports
    function automatic parse_result_t parse_byte(input logic [7:0] b, input logic eor);
        parse_result_t r;
        tag_t          t;
        logic          lst;
        t   = TAG_HEADER;
        lst = 1'b0;
        case (cur_phase)
            PH_VERSION:    cur_phase = PH_PROFILE;
            PH_PROFILE:
            begin
                got_profile = b;
                cur_phase   = PH_COMPAT;
            end
            PH_COMPAT:
            begin
                got_compat = b;
                cur_phase  = PH_LEVEL;
            end
            PH_LEVEL:
            begin
                got_level = b;
                cur_phase = PH_LENSIZE;
            end
            PH_LENSIZE:
            begin
                got_len_size = b[1:0];
                cur_phase    = PH_SPS_COUNT;
            end
            PH_SPS_COUNT:
            begin
                // only the low five bits carry the sps count
                if ({3'b000, b[4:0]} > MAX_SET_COUNT)
                begin
                    got_status = ST_MANY;
                    cur_phase  = PH_ERROR;
                end
                else
                    cur_phase = PH_SPS_LEN_HI;
            end
            PH_SPS_LEN_HI:
            begin
                got_sps_len = {b, 8'h00};
                cur_phase   = PH_SPS_LEN_LO;
            end
            PH_SPS_LEN_LO:
            begin
                got_sps_len = {got_sps_len[15:8], b};
                bytes_left  = got_sps_len;
                cur_phase   = (bytes_left != 0) ? PH_SPS_DATA : PH_PPS_COUNT;
            end
            PH_SPS_DATA:
            begin
                t = TAG_SPS;
                if (bytes_left <= 1)
                begin
                    lst        = 1'b1;
                    bytes_left = '0;
                    cur_phase  = PH_PPS_COUNT;
                end
                else
                    bytes_left = bytes_left - 1'b1;
            end
            PH_PPS_COUNT:
            begin
                // the pps count uses the whole byte
                if (b > MAX_SET_COUNT)
                begin
                    got_status = ST_MANY;
                    cur_phase  = PH_ERROR;
                end
                else
                    cur_phase = PH_PPS_LEN_HI;
            end
            PH_PPS_LEN_HI:
            begin
                got_pps_len = {b, 8'h00};
                cur_phase   = PH_PPS_LEN_LO;
            end
            PH_PPS_LEN_LO:
            begin
                got_pps_len = {got_pps_len[15:8], b};
                bytes_left  = got_pps_len;
                if (bytes_left != 0)
                    cur_phase = PH_PPS_DATA;
                else
                begin
                    cur_phase  = PH_DONE;
                    got_status = ST_DONE;
                end
            end
            PH_PPS_DATA:
            begin
                t = TAG_PPS;
                if (bytes_left <= 1)
                begin
                    lst        = 1'b1;
                    bytes_left = '0;
                    cur_phase  = PH_DONE;
                    got_status = ST_DONE;
                end
                else
                    bytes_left = bytes_left - 1'b1;
            end
            default:       t = TAG_IGNORED;  // done or error
        endcase

        // early end only counts while nothing else has been decided
        if (eor && got_status == ST_BUSY)
            got_status = ST_TRUNC;

        r.data     = b;
        r.tag      = t;
        r.last     = lst;
        r.status   = got_status;
        r.profile  = got_profile;
        r.compat   = got_compat;
        r.level    = got_level;
        r.len_size = got_len_size;
        r.sps_len  = got_sps_len;
        r.pps_len  = got_pps_len;

        // end of record restarts the parser after the word is formed
        if (eor)
            clear_parser();
        return r;
    endfunction

    function automatic string describe(input parse_result_t r);
        return $sformatf({"byte=%02h tag=%0d last=%0d status=%0d profile=%02h compat=%02h",
                          " level=%02h lsize=%0d sps_len=%04h pps_len=%04h"},
                         r.data, r.tag, r.last, r.status, r.profile, r.compat,
                         r.level, r.len_size, r.sps_len, r.pps_len);
    endfunction

    // receiver: ready drops in random bursts while idling is on
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idling_on && $urandom_range(0, 4) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end
        else
            out_ready <= 1'b1;
    end

    // result checker: compare each accepted word with the oldest prediction
    always @(posedge clk)
    begin : check_results
        parse_result_t want;
        parse_result_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen.data     = out_byte;
            seen.tag      = byte_tag;
            seen.last     = set_last;
            seen.status   = parse_status;
            seen.profile  = profile_idc;
            seen.compat   = compat_flags;
            seen.level    = level_idc;
            seen.len_size = length_size_minus_one;
            seen.sps_len  = sps_length;
            seen.pps_len  = pps_length;
            if (pending_results.size() == 0)
            begin
                if (mismatches < MAX_SHOWN)
                    $display("%0t: result word with nothing predicted: %s",
                             $realtime, describe(seen));
                mismatches = mismatches + 1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (want !== seen)
                begin
                    if (mismatches < MAX_SHOWN)
                    begin
                        $display("%0t: mismatch", $realtime);
                        $display("  expected %s", describe(want));
                        $display("  actual   %s", describe(seen));
                    end
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    // sender: optional idle burst, then hold the word until it is taken
    task automatic send_word(input record_word_t w);
        parse_result_t r;
        int            gap;
        gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        in_byte       <= w.data;
        end_of_record <= w.eor;
        do
            @(posedge clk);
        while (!in_ready);
        r = parse_byte(w.data, w.eor);
        if (w.fixed)
        begin
            r.tag    = w.tag;
            r.last   = w.last;
            r.status = w.status;
        end
        pending_results.push_back(r);
        if (r.tag != TAG_IGNORED)
            parsed_words++;
    endtask

    // stop sending and let every predicted word come out
    task automatic pause_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // length field plus payload; the payload of a wide length is cut at RECORD_CAP record bytes
    task automatic add_param_set(input bit wide);
        logic [15:0] len;
        int          n;
        if (wide)
            len = 16'($urandom);
        else if ($urandom_range(0, 7) == 0)
            len = 16'($urandom_range(7, 40));
        else
            len = 16'($urandom_range(0, 6));
        record_q.push_back(len[15:8]);
        record_q.push_back(len[7:0]);
        n = 0;
        while (n < len && (!wide || record_q.size() < RECORD_CAP))
        begin
            record_q.push_back(8'($urandom));
            n++;
        end
    endtask

    // random record: well formed, cut short, too many sets, or noise
    task automatic build_record();
        int kind;
        int cut;
        bit wide;
        record_q.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 85)
        begin
            repeat ($urandom_range(1, 20)) record_q.push_back(8'($urandom));
            return;
        end
        // version, profile, compatibility, level, length size
        repeat (5) record_q.push_back(8'($urandom));
        if (kind >= 72 && $urandom_range(0, 1) == 1)
        begin
            // sps count above one
            record_q.push_back({3'($urandom), 5'($urandom_range(2, 31))});
            repeat ($urandom_range(0, 3)) record_q.push_back(8'($urandom));
            return;
        end
        wide = (kind >= 55 && kind < 72) && ($urandom_range(0, 1) == 1);
        record_q.push_back({3'($urandom), 5'($urandom_range(0, 1))});
        add_param_set(wide);
        if (kind >= 72)
        begin
            // pps count above one
            record_q.push_back(8'($urandom_range(2, 255)));
            repeat ($urandom_range(0, 3)) record_q.push_back(8'($urandom));
            return;
        end
        record_q.push_back(8'($urandom_range(0, 1)));
        add_param_set(wide);
        if (kind >= 55)
        begin
            // end the record somewhere before it is complete
            cut = $urandom_range(1, record_q.size() - 1);
            while (record_q.size() > cut)
                void'(record_q.pop_back());
        end
        else if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) record_q.push_back(8'($urandom));
    endtask

    initial
    begin : stimulus
        record_word_t w;
        clear_parser();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_WORDS[i])
            send_word(DIRECTED_WORDS[i]);
        pause_for_results();

        while (parsed_words < WORD_TARGET)
        begin
            if (parsed_words >= WORD_TARGET - CALM_TAIL)
                idling_on = 1'b0;
            else if ($urandom_range(0, 39) == 0)
                pause_for_results();
            build_record();
            foreach (record_q[i])
            begin
                w       = '0;
                w.data  = record_q[i];
                w.eor   = (i == record_q.size() - 1);
                send_word(w);
            end
        end

        pause_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
sv/avcc_pkg.sv
sv/avcc_config_record_parser.sv
tb/sv/avcc_config_record_parser_tb.sv
